### hw/rtl/assert_macros.svh
// Assertion macros included by json_token_lexer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, ignored while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/jtl_pkg.sv
`timescale 1ns / 1ps

package jtl_pkg;

  localparam int DEPTH = 8;
  localparam int QPTR_BITS = $clog2(DEPTH);
  localparam int QCNT_BITS = QPTR_BITS + 1;

  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COLON    = 4'd4;
  localparam logic [3:0] KIND_COMMA    = 4'd5;
  localparam logic [3:0] KIND_STRING   = 4'd6;
  localparam logic [3:0] KIND_NUMBER   = 4'd7;
  localparam logic [3:0] KIND_NULL     = 4'd8;
  localparam logic [3:0] KIND_BOOL     = 4'd9;
  localparam logic [3:0] KIND_NONE     = 4'd0;

  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_LOWER_E   = 8'h65;
  localparam logic [7:0] CH_UPPER_E   = 8'h45;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_F         = 8'h66;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_STRING  = 5'b00010,
    MODE_NUMBER  = 5'b00100,
    MODE_LITERAL = 5'b01000,
    MODE_ERROR   = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [7:0]  value_byte;
    logic        byte_valid;
    logic        token_first;
    logic        token_last;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [1:0]  error_code;
    logic        run_last;
  } tok_t;

  function automatic tok_t make_item(input logic [3:0] kind, input logic [7:0] val,
                                     input logic bv, input logic first, input logic last,
                                     input logic [15:0] line, input logic [15:0] col,
                                     input logic [1:0] err);
    tok_t t;
    t.token_kind   = kind;
    t.value_byte   = val;
    t.byte_valid   = bv;
    t.token_first  = first;
    t.token_last   = last;
    t.start_line   = line;
    t.start_column = col;
    t.error_code   = err;
    t.run_last     = 1'b0;
    return t;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    logic [2:0] len;
    case (kind)
      LIT_FALSE: len = 3'd5;
      default:   len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] c;
    case (kind)
      LIT_TRUE: begin
        case (pos)
          3'd0:    c = 8'h74;
          3'd1:    c = 8'h72;
          3'd2:    c = 8'h75;
          3'd3:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (pos)
          3'd0:    c = 8'h66;
          3'd1:    c = 8'h61;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h73;
          3'd4:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    c = 8'h6E;
          3'd1:    c = 8'h75;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

### hw/rtl/jtl_in_if.sv
`timescale 1ns / 1ps

interface jtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

### hw/rtl/jtl_out_if.sv
`timescale 1ns / 1ps

interface jtl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  value_byte;
  logic        byte_valid;
  logic        token_first;
  logic        token_last;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [1:0]  error_code;
  logic        run_last;

  modport source (output valid, output token_kind, output value_byte, output byte_valid,
                  output token_first, output token_last, output start_line,
                  output start_column, output error_code, output run_last, input ready);
  modport sink (input valid, input token_kind, input value_byte, input byte_valid,
                input token_first, input token_last, input start_line,
                input start_column, input error_code, input run_last, output ready);
endinterface

### hw/rtl/json_token_lexer.sv
// JSON token lexer.
// The text_in channel carries one byte of JSON text per request, with end_of_text
// set on the final byte of a text. The token_out channel carries token events:
// one request per punctuation mark or literal, and for strings and numbers an
// opening request, one per content byte and a closing request.
// Each text byte is held in an input register and decoded from there, once the
// queue has room. Its zero to three results are written at once into an
// eight-entry result queue, from which token_out offers them in order.
// Throughput is one text byte per cycle; the input side pauses only while the
// queue has fewer than three free entries, so a burst of multi-result bytes is
// absorbed and the sustained rate is set by the one result per cycle that the
// queue can deliver.
// When token_out is stalled, results wait in the queue and text_in keeps taking
// bytes until the queue is nearly full.
// A synchronous reset empties the queue and the input register and returns the
// lexer to line 1, column 0, outside any token. The position and token state,
// but not the queue, return to these values after every byte marked end_of_text.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module json_token_lexer
  import jtl_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  jtl_in_if.sink     text_in,
  jtl_out_if.source  token_out
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic                     iv;
  logic [7:0]               ib;
  logic                     ie;
  logic                     proc;

  mode_t                    mode;
  mode_t                    mode_next;
  logic                     pb;
  logic                     pb_next;
  logic [1:0]               lk;
  logic [1:0]               lk_next;
  logic [2:0]               lp;
  logic [2:0]               lp_next;
  logic [POSITION_BITS-1:0] line_count;
  logic [POSITION_BITS-1:0] line_next;
  logic [POSITION_BITS-1:0] column_count;
  logic [POSITION_BITS-1:0] col_next;
  logic [POSITION_BITS-1:0] token_line;
  logic [POSITION_BITS-1:0] tline_next;
  logic [POSITION_BITS-1:0] token_column;
  logic [POSITION_BITS-1:0] tcol_next;

  tok_t                     items [3];
  logic [1:0]               n;
  logic                     run_idle;
  logic                     punct;
  logic [3:0]               pkind;

  tok_t                     fifo [DEPTH];
  logic [QPTR_BITS-1:0]     wr_ptr;
  logic [QPTR_BITS-1:0]     rd_ptr;
  logic [QCNT_BITS-1:0]     count;
  logic [1:0]               n_push;
  logic                     pop;

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POSITION_BITS'(1);
  endfunction

  function automatic logic [15:0] clamp_pos(input logic [POSITION_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  assign proc          = iv && (count <= QCNT_BITS'(DEPTH - 3));
  assign text_in.ready = !iv || proc;
  assign n_push        = proc ? n : 2'd0;
  assign pop           = token_out.valid && token_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (text_in.valid && text_in.ready) begin
      iv <= 1'b1;
    end else if (proc) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      ib <= text_in.text_byte;
      ie <= text_in.end_of_text;
    end
  end

  always_comb begin
    mode_next  = mode;
    pb_next    = pb;
    lk_next    = lk;
    lp_next    = lp;
    line_next  = line_count;
    col_next   = sat_inc(column_count);
    tline_next = token_line;
    tcol_next  = token_column;
    items      = '{default: '0};
    n          = 2'd0;
    run_idle   = 1'b0;
    punct      = 1'b1;
    pkind      = KIND_LBRACE;

    case (mode)
      MODE_STRING: begin
        if (pb) begin
          pb_next = 1'b0;
          if (ib == CH_QUOTE) begin
            items[n] = make_item(KIND_STRING, ib, 1'b1, 1'b0, 1'b0, clamp_pos(tline_next),
                                 clamp_pos(tcol_next), ERR_NONE);
            n = n + 2'd1;
          end else begin
            items[n] = make_item(KIND_STRING, CH_BACKSLASH, 1'b1, 1'b0, 1'b0,
                                 clamp_pos(tline_next), clamp_pos(tcol_next), ERR_NONE);
            n = n + 2'd1;
            items[n] = make_item(KIND_STRING, ib, 1'b1, 1'b0, 1'b0, clamp_pos(tline_next),
                                 clamp_pos(tcol_next), ERR_NONE);
            n = n + 2'd1;
          end
        end else if (ib == CH_BACKSLASH) begin
          pb_next = 1'b1;
        end else if (ib == CH_QUOTE) begin
          items[n] = make_item(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1, clamp_pos(tline_next),
                               clamp_pos(tcol_next), ERR_NONE);
          n = n + 2'd1;
          mode_next = MODE_IDLE;
        end else begin
          items[n] = make_item(KIND_STRING, ib, 1'b1, 1'b0, 1'b0, clamp_pos(tline_next),
                               clamp_pos(tcol_next), ERR_NONE);
          n = n + 2'd1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(ib) || ib == CH_DOT || ib == CH_LOWER_E || ib == CH_UPPER_E) begin
          items[n] = make_item(KIND_NUMBER, ib, 1'b1, 1'b0, 1'b0, clamp_pos(tline_next),
                               clamp_pos(tcol_next), ERR_NONE);
          n = n + 2'd1;
        end else begin
          items[n] = make_item(KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, clamp_pos(tline_next),
                               clamp_pos(tcol_next), ERR_NONE);
          n = n + 2'd1;
          mode_next = MODE_IDLE;
          run_idle  = 1'b1;
        end
      end
      MODE_LITERAL: begin
        if ((lp < lit_len(lk)) && (ib == lit_char(lk, lp))) begin
          lp_next = lp + 3'd1;
          if (lp_next >= lit_len(lk)) begin
            if (lk == LIT_TRUE || lk == LIT_FALSE) begin
              items[n] = make_item(KIND_BOOL, {7'd0, lk == LIT_TRUE}, 1'b1, 1'b1, 1'b1,
                                   clamp_pos(tline_next), clamp_pos(tcol_next), ERR_NONE);
            end else begin
              items[n] = make_item(KIND_NULL, 8'h00, 1'b0, 1'b1, 1'b1,
                                   clamp_pos(tline_next), clamp_pos(tcol_next), ERR_NONE);
            end
            n = n + 2'd1;
            mode_next = MODE_IDLE;
            lp_next   = 3'd0;
          end
        end else begin
          items[n] = make_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0, clamp_pos(line_next),
                               clamp_pos(col_next), ERR_UNEXPECTED);
          n = n + 2'd1;
          mode_next = MODE_ERROR;
        end
      end
      MODE_IDLE: begin
        run_idle = 1'b1;
      end
      default: begin
      end
    endcase

    // A byte seen outside any token, or the byte that ended a number.
    if (run_idle) begin
      case (ib)
        CH_LBRACE:   pkind = KIND_LBRACE;
        CH_RBRACE:   pkind = KIND_RBRACE;
        CH_LBRACKET: pkind = KIND_LBRACKET;
        CH_RBRACKET: pkind = KIND_RBRACKET;
        CH_COLON:    pkind = KIND_COLON;
        CH_COMMA:    pkind = KIND_COMMA;
        default:     punct = 1'b0;
      endcase
      if (punct) begin
        tline_next = line_next;
        tcol_next  = col_next;
        items[n] = make_item(pkind, ib, 1'b1, 1'b1, 1'b1, clamp_pos(tline_next),
                             clamp_pos(tcol_next), ERR_NONE);
        n = n + 2'd1;
      end else if (ib == CH_QUOTE) begin
        tline_next = line_next;
        tcol_next  = col_next;
        mode_next  = MODE_STRING;
        pb_next    = 1'b0;
        items[n] = make_item(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, clamp_pos(tline_next),
                             clamp_pos(tcol_next), ERR_NONE);
        n = n + 2'd1;
      end else if (is_digit(ib) || ib == CH_MINUS) begin
        tline_next = line_next;
        tcol_next  = col_next;
        mode_next  = MODE_NUMBER;
        items[n] = make_item(KIND_NUMBER, ib, 1'b1, 1'b1, 1'b0, clamp_pos(tline_next),
                             clamp_pos(tcol_next), ERR_NONE);
        n = n + 2'd1;
      end else if (ib == CH_N || ib == CH_T || ib == CH_F) begin
        tline_next = line_next;
        tcol_next  = col_next;
        mode_next  = MODE_LITERAL;
        lk_next    = (ib == CH_N) ? LIT_NULL : ((ib == CH_T) ? LIT_TRUE : LIT_FALSE);
        lp_next    = 3'd1;
      end else if (ib == CH_NEWLINE) begin
        line_next = sat_inc(line_count);
        col_next  = '0;
      end else if (ib == CH_SPACE || ib == CH_TAB || ib == CH_CR) begin
        mode_next = mode_next;
      end else begin
        items[n] = make_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0, clamp_pos(line_next),
                             clamp_pos(col_next), ERR_UNEXPECTED);
        n = n + 2'd1;
        mode_next = MODE_ERROR;
      end
    end

    if (ie) begin
      if (mode_next == MODE_STRING) begin
        items[n] = make_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0, clamp_pos(tline_next),
                             clamp_pos(tcol_next), ERR_UNTERMINATED);
        n = n + 2'd1;
      end else if (mode_next == MODE_NUMBER) begin
        items[n] = make_item(KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, clamp_pos(tline_next),
                             clamp_pos(tcol_next), ERR_NONE);
        n = n + 2'd1;
      end else if (mode_next == MODE_LITERAL) begin
        items[n] = make_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0, clamp_pos(line_next),
                             clamp_pos(col_next), ERR_UNEXPECTED);
        n = n + 2'd1;
      end
      mode_next  = MODE_IDLE;
      pb_next    = 1'b0;
      lk_next    = LIT_NULL;
      lp_next    = 3'd0;
      line_next  = POSITION_BITS'(1);
      col_next   = '0;
      tline_next = POSITION_BITS'(1);
      tcol_next  = POSITION_BITS'(1);
    end

    if (n != 2'd0) begin
      items[n - 2'd1].run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      pb           <= 1'b0;
      lk           <= LIT_NULL;
      lp           <= 3'd0;
      line_count   <= POSITION_BITS'(1);
      column_count <= '0;
      token_line   <= POSITION_BITS'(1);
      token_column <= POSITION_BITS'(1);
    end else if (proc) begin
      mode         <= mode_next;
      pb           <= pb_next;
      lk           <= lk_next;
      lp           <= lp_next;
      line_count   <= line_next;
      column_count <= col_next;
      token_line   <= tline_next;
      token_column <= tcol_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (proc && (2'(i) < n)) begin
        fifo[wr_ptr + QPTR_BITS'(i)] <= items[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_BITS'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      count <= count + QCNT_BITS'(n_push) - QCNT_BITS'(pop);
    end
  end

  assign token_out.valid        = (count != '0);
  assign token_out.token_kind   = fifo[rd_ptr].token_kind;
  assign token_out.value_byte   = fifo[rd_ptr].value_byte;
  assign token_out.byte_valid   = fifo[rd_ptr].byte_valid;
  assign token_out.token_first  = fifo[rd_ptr].token_first;
  assign token_out.token_last   = fifo[rd_ptr].token_last;
  assign token_out.start_line   = fifo[rd_ptr].start_line;
  assign token_out.start_column = fifo[rd_ptr].start_column;
  assign token_out.error_code   = fifo[rd_ptr].error_code;
  assign token_out.run_last     = fifo[rd_ptr].run_last;

  `ASSERT_ALWAYS(a_idle_after_reset, $past(rst) |-> (mode == MODE_IDLE), "lexer not idle after reset")
  `ASSERT_CLK(a_backslash_in_string, pb |-> (mode == MODE_STRING), "held backslash outside a string")
  `ASSERT_CLK(a_queue_count, 1'b1 |=> (count == QCNT_BITS'($past(count) + QCNT_BITS'($past(n_push)) - QCNT_BITS'($past(pop)))), "result queue count drifted")
  `ASSERT_CLK(a_queue_bound, count <= QCNT_BITS'(DEPTH), "result queue overflow")

endmodule
